FILE: sv/ktl_pkg.sv
// ----------------------------------------------------------------------------
// ktl_pkg
// Types and constants shared by the keyframe track interpolator.
// ----------------------------------------------------------------------------
package ktl_pkg;

  // field widths
  localparam int TIME_W   = 32;
  localparam int VAL_W    = 32;
  localparam int COUNT_W  = 7;
  localparam int INDEX_W  = 6;
  localparam int STATUS_W = 2;

  // divider operand widths: |t - t0| * 2^16 over |t1 - t0|
  localparam int NUM_W = 49;
  localparam int DEN_W = 33;

  // status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_ZERO  = 2'd2;

  // function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  // one keyframe as stored in the track memory
  typedef struct packed {
    logic [TIME_W-1:0] ktime;
    logic [VAL_W-1:0]  x;
    logic [VAL_W-1:0]  y;
    logic [VAL_W-1:0]  z;
  } key_t;

  localparam int KEY_W = $bits(key_t);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ONE_RD,
    S_ONE,
    S_HI_RD,
    S_HI_CHK,
    S_LO_RD,
    S_LO,
    S_DIV,
    S_MUL,
    S_ACC
  } state_t;

  // divider handshake
  typedef struct packed {
    logic             go;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } div_rsp_t;

endpackage

FILE: sv/keyframe_track_lerp.sv
// ----------------------------------------------------------------------------
// keyframe_track_lerp
// One animation track of keyframes in a memory, queried with linear
// interpolation and extrapolation between neighboring keys.
// ----------------------------------------------------------------------------
//  channel  ports                                   handshake
//  input    start, busy, in_func .. in_z            start && !busy
//  result   out_valid, out_x .. out_z, out_status   one-cycle strobe
//  config   cfg_valid, cfg_ready, cfg_data          valid && ready
//
//  a load word writes the memory at the accept edge.
//  a query of two or more keys scans keys one memory read per key, then,
//  unless the chosen pair has equal times, runs a 49-step divider for
//  the factor and one shared multiplier for three components.
//  an empty track answers the cycle after accept.
//  reset clears control only; memory contents stay undefined until loaded.
//  the result is strobed for one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module keyframe_track_lerp #(
  parameter int KEYS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        start,
  output logic        busy,
  input  logic        in_func,
  input  logic [5:0]  in_key_index,
  input  logic [31:0] in_sample_time,
  input  logic [31:0] in_x,
  input  logic [31:0] in_y,
  input  logic [31:0] in_z,
  // result channel
  output logic        out_valid,
  output logic [31:0] out_x,
  output logic [31:0] out_y,
  output logic [31:0] out_z,
  output logic [1:0]  out_status,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data
);

  localparam int AW = (KEYS > 1) ? $clog2(KEYS) : 1;
  localparam int CW = $clog2(KEYS + 1);

  ktl_pkg::state_t state_r, state_nxt;

  logic [6:0]          key_count_r;
  logic [CW-1:0]       n_r, n_nxt, n_w;
  logic [AW-1:0]       addr_r, addr_nxt;
  logic [AW-1:0]       j_r, j_nxt;
  logic [31:0]         t_r, t_nxt;
  ktl_pkg::key_t       hi_r, hi_nxt, lo_r, lo_nxt;
  logic                neg_r, neg_nxt;
  logic signed [31:0]  factor_r, factor_nxt;
  logic [1:0]          comp_r, comp_nxt;
  logic signed [64:0]  prod_r, prod_nxt;
  logic                ov_r, ov_nxt;
  logic [31:0]         ox_r, ox_nxt, oy_r, oy_nxt, oz_r, oz_nxt;
  logic [1:0]          os_r, os_nxt;

  logic                accept;
  logic                ram_we;
  ktl_pkg::key_t       wkey, rkey;
  logic [31:0]         cnt_ext;
  ktl_pkg::div_req_t   dreq;
  ktl_pkg::div_rsp_t   drsp;
  logic signed [32:0]  dt_s, nd_s, diff_s;
  logic [32:0]         dt_mag, nd_mag;
  logic [31:0]         v0_c, v1_c;
  logic signed [64:0]  rnd_s, sum_s;
  logic [31:0]         res_c;

  assign accept    = start && !busy;
  assign busy      = (state_r != ktl_pkg::S_IDLE);
  assign cfg_ready = 1'b1;

  // keys in use, clamped to the track depth
  assign cnt_ext = 32'(key_count_r);
  assign n_w     = (cnt_ext > 32'(KEYS)) ? CW'(KEYS) : CW'(cnt_ext);

  // load words write the track memory at the accept edge
  assign ram_we     = accept && (in_func == ktl_pkg::FUNC_LOAD) &&
                      (32'(in_key_index) < 32'(KEYS));
  assign wkey.ktime = in_sample_time;
  assign wkey.x     = in_x;
  assign wkey.y     = in_y;
  assign wkey.z     = in_z;

  ktl_ram #(
    .WIDTH (ktl_pkg::KEY_W),
    .DEPTH (KEYS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_key_index)),
    .wdata (wkey),
    .raddr (addr_r),
    .rdata (rkey)
  );

  // interval and offset of the chosen pair
  always_comb begin
    dt_s   = $signed({1'b0, hi_r.ktime}) - $signed({1'b0, rkey.ktime});
    nd_s   = $signed({1'b0, t_r}) - $signed({1'b0, rkey.ktime});
    dt_mag = dt_s[32] ? 33'(-dt_s) : 33'(dt_s);
    nd_mag = nd_s[32] ? 33'(-nd_s) : 33'(nd_s);
  end

  assign dreq.num = {nd_mag, 16'b0};
  assign dreq.den = dt_mag;
  assign dreq.go  = (state_r == ktl_pkg::S_LO) && (dt_s != 33'sd0);

  ktl_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  // component select, rounding add and saturation
  always_comb begin
    case (comp_r)
      2'd0:    begin v0_c = lo_r.x; v1_c = hi_r.x; end
      2'd1:    begin v0_c = lo_r.y; v1_c = hi_r.y; end
      default: begin v0_c = lo_r.z; v1_c = hi_r.z; end
    endcase
    diff_s = $signed({v1_c[31], v1_c}) - $signed({v0_c[31], v0_c});
    rnd_s  = (prod_r + 65'sd32768) >>> 16;
    sum_s  = rnd_s + 65'($signed(v0_c));
    if (sum_s > 65'sd2147483647) begin
      res_c = 32'h7FFF_FFFF;
    end else if (sum_s < -65'sd2147483648) begin
      res_c = 32'h8000_0000;
    end else begin
      res_c = sum_s[31:0];
    end
  end

  // sequencer: next state and datapath
  always_comb begin
    state_nxt  = state_r;
    n_nxt      = n_r;
    addr_nxt   = addr_r;
    j_nxt      = j_r;
    t_nxt      = t_r;
    hi_nxt     = hi_r;
    lo_nxt     = lo_r;
    neg_nxt    = neg_r;
    factor_nxt = factor_r;
    comp_nxt   = comp_r;
    prod_nxt   = prod_r;
    ov_nxt     = 1'b0;
    ox_nxt     = ox_r;
    oy_nxt     = oy_r;
    oz_nxt     = oz_r;
    os_nxt     = os_r;
    case (state_r)
      ktl_pkg::S_IDLE: begin
        if (accept && (in_func == ktl_pkg::FUNC_QUERY)) begin
          t_nxt = in_sample_time;
          n_nxt = n_w;
          if (n_w == CW'(0)) begin
            ox_nxt = '0;
            oy_nxt = '0;
            oz_nxt = '0;
            os_nxt = ktl_pkg::STAT_EMPTY;
            ov_nxt = 1'b1;
          end else if (n_w == CW'(1)) begin
            addr_nxt  = '0;
            state_nxt = ktl_pkg::S_ONE_RD;
          end else begin
            addr_nxt  = AW'(1);
            j_nxt     = AW'(1);
            state_nxt = ktl_pkg::S_HI_RD;
          end
        end
      end
      ktl_pkg::S_ONE_RD: state_nxt = ktl_pkg::S_ONE;
      ktl_pkg::S_ONE: begin
        ox_nxt    = rkey.x;
        oy_nxt    = rkey.y;
        oz_nxt    = rkey.z;
        os_nxt    = ktl_pkg::STAT_OK;
        ov_nxt    = 1'b1;
        state_nxt = ktl_pkg::S_IDLE;
      end
      ktl_pkg::S_HI_RD: state_nxt = ktl_pkg::S_HI_CHK;
      ktl_pkg::S_HI_CHK: begin
        // stop at the first key later than t, or at the last key
        if ((t_r < rkey.ktime) || (32'(j_r) == 32'(n_r) - 32'd1)) begin
          hi_nxt    = rkey;
          addr_nxt  = j_r - AW'(1);
          state_nxt = ktl_pkg::S_LO_RD;
        end else begin
          j_nxt     = j_r + AW'(1);
          addr_nxt  = j_r + AW'(1);
          state_nxt = ktl_pkg::S_HI_RD;
        end
      end
      ktl_pkg::S_LO_RD: state_nxt = ktl_pkg::S_LO;
      ktl_pkg::S_LO: begin
        lo_nxt  = rkey;
        neg_nxt = nd_s[32] ^ dt_s[32];
        if (dt_s == 33'sd0) begin
          ox_nxt    = rkey.x;
          oy_nxt    = rkey.y;
          oz_nxt    = rkey.z;
          os_nxt    = ktl_pkg::STAT_ZERO;
          ov_nxt    = 1'b1;
          state_nxt = ktl_pkg::S_IDLE;
        end else begin
          state_nxt = ktl_pkg::S_DIV;
        end
      end
      ktl_pkg::S_DIV: begin
        if (drsp.done) begin
          // saturate the signed factor
          if (neg_r) begin
            factor_nxt = (drsp.quot > 49'h0_8000_0000) ? 32'sh8000_0000
                                                       : 32'(-drsp.quot);
          end else begin
            factor_nxt = (drsp.quot > 49'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                       : drsp.quot[31:0];
          end
          comp_nxt  = 2'd0;
          state_nxt = ktl_pkg::S_MUL;
        end
      end
      ktl_pkg::S_MUL: begin
        prod_nxt  = 65'(diff_s) * 65'(factor_r);
        state_nxt = ktl_pkg::S_ACC;
      end
      ktl_pkg::S_ACC: begin
        case (comp_r)
          2'd0:    ox_nxt = res_c;
          2'd1:    oy_nxt = res_c;
          default: oz_nxt = res_c;
        endcase
        if (comp_r == 2'd2) begin
          os_nxt    = ktl_pkg::STAT_OK;
          ov_nxt    = 1'b1;
          state_nxt = ktl_pkg::S_IDLE;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = ktl_pkg::S_MUL;
        end
      end
      default: state_nxt = ktl_pkg::S_IDLE;
    endcase
  end

  // state register and control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ktl_pkg::S_IDLE;
      ov_r        <= 1'b0;
      key_count_r <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      if (cfg_valid && cfg_ready) begin
        key_count_r <= cfg_data;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    addr_r   <= addr_nxt;
    j_r      <= j_nxt;
    t_r      <= t_nxt;
    hi_r     <= hi_nxt;
    lo_r     <= lo_nxt;
    neg_r    <= neg_nxt;
    factor_r <= factor_nxt;
    comp_r   <= comp_nxt;
    prod_r   <= prod_nxt;
    ox_r     <= ox_nxt;
    oy_r     <= oy_nxt;
    oz_r     <= oz_nxt;
    os_r     <= os_nxt;
  end

  assign out_valid  = ov_r;
  assign out_x      = ox_r;
  assign out_y      = oy_r;
  assign out_z      = oz_r;
  assign out_status = os_r;

endmodule

FILE: sv/ktl_ram.sv
// ----------------------------------------------------------------------------
// ktl_ram
// Generic memory, one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module ktl_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/ktl_div.sv
// ----------------------------------------------------------------------------
// ktl_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ktl_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ktl_pkg::div_req_t req,
  output ktl_pkg::div_rsp_t rsp
);

  localparam int NW = ktl_pkg::NUM_W;
  localparam int DW = ktl_pkg::DEN_W;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] quot_r, quot_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          run_r, run_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   rem_sh;
  logic [DW:0]   rem_sub;

  // one shift and subtract step
  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    rem_sh   = {rem_r, quot_r[NW-1]};
    rem_sub  = rem_sh - {1'b0, den_r};
    if (req.go) begin
      quot_nxt = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
      cnt_nxt  = CW'(NW);
      run_nxt  = 1'b1;
    end else if (run_r) begin
      if (rem_sh >= {1'b0, den_r}) begin
        rem_nxt  = rem_sub[DW-1:0];
        quot_nxt = {quot_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh[DW-1:0];
        quot_nxt = {quot_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule
